FILE: hdl/bfpa_pkg.sv
package bfpa_pkg;

    localparam int ADDR_W     = 10;  // width of data offsets on the ports
    localparam int REQ_IN_W   = 16;  // width of the request size port
    localparam int REQ_W      = 17;  // rounded request, 65535 rounds to 65536
    localparam int STATUS_W   = 2;
    localparam int ALIGN_MASK = 7;
    localparam int MIN_SPLIT  = 8;   // smallest data area worth splitting off

    localparam logic FUNC_ALLOC = 1'b0;
    localparam logic FUNC_FREE  = 1'b1;

    localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
    localparam logic [STATUS_W-1:0] ST_OOM      = 2'd1;
    localparam logic [STATUS_W-1:0] ST_BAD_FREE = 2'd2;

    typedef logic t_alu_op;
    localparam t_alu_op ALU_SUB  = 1'b0;  // a - b, with a >= b flag
    localparam t_alu_op ALU_ADDH = 1'b1;  // a + b + header bytes

endpackage

FILE: hdl/bfpa_ram.sv
module bfpa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: hdl/bfpa_alu.sv
module bfpa_alu #(
    parameter int W   = 17,
    parameter int HDR = 24
) (
    input  bfpa_pkg::t_alu_op i_op,
    input  logic [W-1:0]      i_a,
    input  logic [W-1:0]      i_b,
    output logic [W-1:0]      o_res,
    output logic              o_ge
);
    import bfpa_pkg::*;

    logic [W:0]   diff;
    logic [W-1:0] addh;

    assign diff = {1'b0, i_a} - {1'b0, i_b};
    assign addh = i_a + i_b + W'(HDR);

    always_comb begin
        o_ge = !diff[W];
        unique case (i_op)
            ALU_SUB:  o_res = diff[W-1:0];
            ALU_ADDH: o_res = addh;
            default:  o_res = diff[W-1:0];
        endcase
    end

endmodule

FILE: hdl/best_fit_pool_allocator_core.sv
// Best-fit pool allocator. The pool is kept as an address-ordered table of
// blocks (header offset, data size, used mark) in a small RAM.
// Command channel: drive i_func, i_req_size, i_free_addr with start; the item
// is taken at a clock edge where start is high and busy is low. busy stays
// high until the result is out. The result (o_status, o_data_addr) is on the
// ports for one cycle with o_done high; the receiver cannot stall it.
// Allocate: one pass over the N table entries through the RAM read port,
// a decision state, for a split a shift of up to N - 1 entries plus an
// insert, then the final write; when nothing fits the result follows the
// decision. Free: a lookup pass, a decision state, then a compaction pass
// that merges free neighbors and a final write. An unmatched free ends
// after the decision state; a free of address 0 answers straight from idle,
// without busy going high.
// One item at a time; the RAM port and the shared add/subtract unit set the
// pace. After reset the block writes the initial free block in S_INIT, with
// busy high, and then waits for commands.
module best_fit_pool_allocator_core #(
    parameter int POOL_BYTES   = 1024,
    parameter int HEADER_BYTES = 24,
    parameter int MAX_BLOCKS   = 32
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic                          i_func,
    input  logic [bfpa_pkg::REQ_IN_W-1:0] i_req_size,
    input  logic [bfpa_pkg::ADDR_W-1:0]   i_free_addr,
    output logic                          o_done,
    output logic [bfpa_pkg::STATUS_W-1:0] o_status,
    output logic [bfpa_pkg::ADDR_W-1:0]   o_data_addr
);
    import bfpa_pkg::*;

    localparam int OW    = $clog2(POOL_BYTES);
    localparam int SW    = OW;
    localparam int IW    = $clog2(MAX_BLOCKS);
    localparam int CW    = $clog2(MAX_BLOCKS + 1);
    localparam int RW    = (OW + 1 > REQ_W) ? OW + 1 : REQ_W;
    localparam int ENT_W = 1 + SW + OW;

    localparam logic [3:0] S_INIT  = 4'd0;
    localparam logic [3:0] S_IDLE  = 4'd1;
    localparam logic [3:0] S_ASCAN = 4'd2;
    localparam logic [3:0] S_FSCAN = 4'd3;
    localparam logic [3:0] S_DEC   = 4'd4;
    localparam logic [3:0] S_SHIFT = 4'd5;
    localparam logic [3:0] S_INS   = 4'd6;
    localparam logic [3:0] S_MARK  = 4'd7;
    localparam logic [3:0] S_MERGE = 4'd8;
    localparam logic [3:0] S_MFIN  = 4'd9;

    logic [3:0]          r_state, n_state;
    logic                r_func, n_func;
    logic [RW-1:0]       r_rsize, n_rsize;
    logic [ADDR_W-1:0]   r_faddr, n_faddr;
    logic [CW-1:0]       r_count, n_count;
    // read stream
    logic [IW-1:0]       r_rd_idx, n_rd_idx;
    logic [IW-1:0]       r_last, n_last;
    logic                r_dir, n_dir;
    logic                r_rd_on, n_rd_on;
    logic                r_vld, n_vld;
    logic [IW-1:0]       r_dat_idx, n_dat_idx;
    // best block (allocate) or matched block (free)
    logic                r_found, n_found;
    logic [IW-1:0]       r_best, n_best;
    logic [SW-1:0]       r_best_diff, n_best_diff;
    logic [OW-1:0]       r_best_off, n_best_off;
    logic [SW-1:0]       r_best_size, n_best_size;
    logic                r_split, n_split;
    // merge pass
    logic                r_pend_used, n_pend_used;
    logic [SW-1:0]       r_pend_size, n_pend_size;
    logic [OW-1:0]       r_pend_off, n_pend_off;
    logic [IW-1:0]       r_wr_idx, n_wr_idx;
    // result
    logic                r_done, n_done;
    logic [STATUS_W-1:0] r_status, n_status;
    logic [ADDR_W-1:0]   r_addr, n_addr;

    logic                ram_we;
    logic [IW-1:0]       ram_waddr;
    logic [ENT_W-1:0]    ram_wdata;
    logic [ENT_W-1:0]    ram_rdata;

    logic                e_used;
    logic [SW-1:0]       e_size;
    logic [OW-1:0]       e_off;
    logic                e_used_eff;
    logic [SW-1:0]       cand_diff;

    t_alu_op             alu_op;
    logic [RW-1:0]       alu_a;
    logic [RW-1:0]       alu_b;
    logic [RW-1:0]       alu_res;
    logic                alu_ge;

    bfpa_ram #(
        .WIDTH(ENT_W),
        .DEPTH(MAX_BLOCKS)
    ) u_ram (
        .i_clk  (i_clk),
        .i_we   (ram_we),
        .i_waddr(ram_waddr),
        .i_wdata(ram_wdata),
        .i_raddr(r_rd_idx),
        .o_rdata(ram_rdata)
    );

    bfpa_alu #(
        .W  (RW),
        .HDR(HEADER_BYTES)
    ) u_alu (
        .i_op (alu_op),
        .i_a  (alu_a),
        .i_b  (alu_b),
        .o_res(alu_res),
        .o_ge (alu_ge)
    );

    assign e_used     = ram_rdata[ENT_W-1];
    assign e_size     = ram_rdata[OW+SW-1:OW];
    assign e_off      = ram_rdata[OW-1:0];
    // the block being freed counts as free during the merge pass
    assign e_used_eff = (r_dat_idx == r_best) ? 1'b0 : e_used;
    assign cand_diff  = alu_res[SW-1:0];

    always_comb begin
        alu_op = ALU_SUB;
        alu_a  = '0;
        alu_b  = '0;
        unique case (r_state)
            S_ASCAN: begin
                alu_a = RW'(e_size);
                alu_b = r_rsize;
            end
            S_FSCAN: begin
                alu_op = ALU_ADDH;
                alu_a  = RW'(e_off);
            end
            S_MERGE: begin
                alu_op = ALU_ADDH;
                alu_a  = RW'(r_pend_size);
                alu_b  = RW'(e_size);
            end
            S_INS: begin
                alu_op = ALU_ADDH;
                alu_a  = RW'(r_best_off);
                alu_b  = r_rsize;
            end
            S_MARK: begin
                alu_op = ALU_ADDH;
                alu_a  = RW'(r_best_off);
            end
            default: begin
                alu_op = ALU_SUB;
            end
        endcase
    end

    always_comb begin
        n_state     = r_state;
        n_func      = r_func;
        n_rsize     = r_rsize;
        n_faddr     = r_faddr;
        n_count     = r_count;
        n_rd_idx    = r_rd_idx;
        n_last      = r_last;
        n_dir       = r_dir;
        n_rd_on     = 1'b0;
        n_vld       = 1'b0;
        n_dat_idx   = r_rd_idx;
        n_found     = r_found;
        n_best      = r_best;
        n_best_diff = r_best_diff;
        n_best_off  = r_best_off;
        n_best_size = r_best_size;
        n_split     = r_split;
        n_pend_used = r_pend_used;
        n_pend_size = r_pend_size;
        n_pend_off  = r_pend_off;
        n_wr_idx    = r_wr_idx;
        n_done      = 1'b0;
        n_status    = r_status;
        n_addr      = r_addr;
        ram_we      = 1'b0;
        ram_waddr   = '0;
        ram_wdata   = '0;

        // streaming reads: one address issued per cycle, data in the next cycle
        if (r_state == S_ASCAN || r_state == S_FSCAN || r_state == S_SHIFT ||
            r_state == S_MERGE) begin
            n_vld   = r_rd_on;
            n_rd_on = r_rd_on;
            if (r_rd_on) begin
                if (r_rd_idx == r_last) begin
                    n_rd_on = 1'b0;
                end else if (r_dir) begin
                    n_rd_idx = r_rd_idx - IW'(1);
                end else begin
                    n_rd_idx = r_rd_idx + IW'(1);
                end
            end
        end

        unique case (r_state)
            S_INIT: begin
                ram_we    = 1'b1;
                ram_waddr = '0;
                ram_wdata = {1'b0, SW'(POOL_BYTES - HEADER_BYTES), OW'(0)};
                n_count   = CW'(1);
                n_state   = S_IDLE;
            end
            S_IDLE: begin
                if (start) begin
                    n_func   = i_func;
                    n_rsize  = (RW'(i_req_size) + RW'(ALIGN_MASK)) & ~RW'(ALIGN_MASK);
                    n_faddr  = i_free_addr;
                    n_found  = 1'b0;
                    n_rd_idx = '0;
                    n_last   = IW'(r_count - CW'(1));
                    n_dir    = 1'b0;
                    n_rd_on  = 1'b1;
                    if (i_func == FUNC_ALLOC) begin
                        n_state = S_ASCAN;
                    end else if (i_free_addr == '0) begin
                        n_rd_on  = 1'b0;
                        n_done   = 1'b1;
                        n_status = ST_OK;
                        n_addr   = '0;
                    end else begin
                        n_state = S_FSCAN;
                    end
                end
            end
            S_ASCAN: begin
                if (r_vld) begin
                    if (!e_used && alu_ge && (!r_found || cand_diff < r_best_diff)) begin
                        n_found     = 1'b1;
                        n_best      = r_dat_idx;
                        n_best_diff = cand_diff;
                        n_best_off  = e_off;
                        n_best_size = e_size;
                    end
                    if (r_dat_idx == r_last) begin
                        n_state = S_DEC;
                    end
                end
            end
            S_FSCAN: begin
                if (r_vld) begin
                    if (!r_found && alu_res == RW'(r_faddr)) begin
                        n_found = 1'b1;
                        n_best  = r_dat_idx;
                    end
                    if (r_dat_idx == r_last) begin
                        n_state = S_DEC;
                    end
                end
            end
            S_DEC: begin
                if (r_func == FUNC_ALLOC) begin
                    if (!r_found) begin
                        n_done   = 1'b1;
                        n_status = ST_OOM;
                        n_addr   = '0;
                        n_state  = S_IDLE;
                    end else begin
                        n_split = (RW'(r_best_diff) >= RW'(HEADER_BYTES + MIN_SPLIT)) &&
                                  (r_count < CW'(MAX_BLOCKS));
                        if (!n_split) begin
                            n_state = S_MARK;
                        end else if (CW'(r_best) + CW'(1) == r_count) begin
                            n_state = S_INS;
                        end else begin
                            // move entries best+1 .. count-1 up by one, top first
                            n_rd_idx = IW'(r_count - CW'(1));
                            n_last   = r_best + IW'(1);
                            n_dir    = 1'b1;
                            n_rd_on  = 1'b1;
                            n_state  = S_SHIFT;
                        end
                    end
                end else begin
                    if (!r_found) begin
                        n_done   = 1'b1;
                        n_status = ST_BAD_FREE;
                        n_addr   = '0;
                        n_state  = S_IDLE;
                    end else begin
                        n_rd_idx = '0;
                        n_last   = IW'(r_count - CW'(1));
                        n_dir    = 1'b0;
                        n_rd_on  = 1'b1;
                        n_wr_idx = '0;
                        n_state  = S_MERGE;
                    end
                end
            end
            S_SHIFT: begin
                if (r_vld) begin
                    ram_we    = 1'b1;
                    ram_waddr = r_dat_idx + IW'(1);
                    ram_wdata = ram_rdata;
                    if (r_dat_idx == r_last) begin
                        n_state = S_INS;
                    end
                end
            end
            S_INS: begin
                ram_we    = 1'b1;
                ram_waddr = r_best + IW'(1);
                ram_wdata = {1'b0,
                             SW'(RW'(r_best_diff) - RW'(HEADER_BYTES)),
                             alu_res[OW-1:0]};
                n_state   = S_MARK;
            end
            S_MARK: begin
                ram_we    = 1'b1;
                ram_waddr = r_best;
                ram_wdata = {1'b1, r_split ? SW'(r_rsize) : r_best_size, r_best_off};
                n_count   = r_count + CW'(r_split);
                n_done    = 1'b1;
                n_status  = ST_OK;
                n_addr    = alu_res[ADDR_W-1:0];
                n_state   = S_IDLE;
            end
            S_MERGE: begin
                if (r_vld) begin
                    if (r_dat_idx == '0) begin
                        n_pend_used = e_used_eff;
                        n_pend_size = e_size;
                        n_pend_off  = e_off;
                    end else if (!r_pend_used && !e_used_eff) begin
                        n_pend_size = alu_res[SW-1:0];
                    end else begin
                        ram_we      = 1'b1;
                        ram_waddr   = r_wr_idx;
                        ram_wdata   = {r_pend_used, r_pend_size, r_pend_off};
                        n_wr_idx    = r_wr_idx + IW'(1);
                        n_pend_used = e_used_eff;
                        n_pend_size = e_size;
                        n_pend_off  = e_off;
                    end
                    if (r_dat_idx == r_last) begin
                        n_state = S_MFIN;
                    end
                end
            end
            S_MFIN: begin
                ram_we    = 1'b1;
                ram_waddr = r_wr_idx;
                ram_wdata = {r_pend_used, r_pend_size, r_pend_off};
                n_count   = CW'(r_wr_idx) + CW'(1);
                n_done    = 1'b1;
                n_status  = ST_OK;
                n_addr    = '0;
                n_state   = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_INIT;
            r_count <= CW'(1);
            r_rd_on <= 1'b0;
            r_vld   <= 1'b0;
            r_found <= 1'b0;
            r_split <= 1'b0;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_rd_on <= n_rd_on;
            r_vld   <= n_vld;
            r_found <= n_found;
            r_split <= n_split;
            r_done  <= n_done;
        end
    end

    always_ff @(posedge i_clk) begin
        r_func      <= n_func;
        r_rsize     <= n_rsize;
        r_faddr     <= n_faddr;
        r_rd_idx    <= n_rd_idx;
        r_last      <= n_last;
        r_dir       <= n_dir;
        r_dat_idx   <= n_dat_idx;
        r_best      <= n_best;
        r_best_diff <= n_best_diff;
        r_best_off  <= n_best_off;
        r_best_size <= n_best_size;
        r_pend_used <= n_pend_used;
        r_pend_size <= n_pend_size;
        r_pend_off  <= n_pend_off;
        r_wr_idx    <= n_wr_idx;
        r_status    <= n_status;
        r_addr      <= n_addr;
    end

    assign busy        = (r_state != S_IDLE);
    assign o_done      = r_done;
    assign o_status    = r_status;
    assign o_data_addr = r_addr;

`ifndef SYNTHESIS
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count != '0) && (r_count <= CW'(MAX_BLOCKS)))
        else $error("block count out of range");

    a_write_in_table: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ram_we |-> (CW'(ram_waddr) <= r_count))
        else $error("table write beyond the last entry");

    a_merge_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_MERGE && r_vld) |-> (r_wr_idx <= r_dat_idx))
        else $error("merge write pointer passed the read pointer");

    a_fail_addr_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_status != ST_OK) |-> (o_data_addr == '0))
        else $error("failed item returned an address");

    a_alloc_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && i_func == FUNC_ALLOC) |=> busy)
        else $error("allocate item did not start work");
`endif

endmodule
